// File: src/ipcm_pkg.sv
// Shared types, constants and the sine table for the iteration palette colormap.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ipcm_pkg;

   localparam int CountWidth     = 16;
   localparam int ColorWidth     = 8;
   localparam int PaletteWidth   = 4;
   localparam int CsrIndexWidth  = 1;
   localparam int CsrDataWidth   = 16;
   localparam int FracBitsDefault = 16;

   localparam logic [CountWidth-1:0]   MaxIterReset = 16'd256;
   localparam logic [PaletteWidth-1:0] PaletteReset = 4'd0;

   localparam int RampGain    = 255;
   localparam int VioletRGain = 148;
   localparam int VioletBGain = 211;

   localparam int SineDepth    = 256;
   localparam int SineIdxWidth = 8;
   localparam int SineOffsetG  = (SineDepth + 1) / 3;
   localparam int SineOffsetB  = (2 * SineDepth + 1) / 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MAX_ITERATIONS = 1'b0,
      CSR_PALETTE        = 1'b1
   } csr_index_type;

   typedef enum logic [PaletteWidth-1:0] {
      PAL_GRAY      = 4'd0,
      PAL_RED       = 4'd1,
      PAL_ORANGE    = 4'd2,
      PAL_YELLOW    = 4'd3,
      PAL_GREEN     = 4'd4,
      PAL_CYAN      = 4'd5,
      PAL_BLUE      = 4'd6,
      PAL_VIOLET    = 4'd7,
      PAL_SINE      = 4'd8,
      PAL_PIECEWISE = 4'd9
   } palette_type;

   localparam logic [7:0] QuarterWave [0:64] = '{
      8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
      8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185,
      8'd188, 8'd190, 8'd193, 8'd196, 8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211,
      8'd213, 8'd215, 8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
      8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244, 8'd245, 8'd246,
      8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254,
      8'd254, 8'd255, 8'd255, 8'd255, 8'd255
   };

   function automatic logic [7:0] half_wave(input logic [6:0] phase);
      logic [7:0] mirror;
      mirror = 8'd128 - {1'b0, phase};
      if (phase <= 7'd64) begin
         return QuarterWave[phase];
      end
      return QuarterWave[mirror[6:0]];
   endfunction

   // The midpoint of the wave is rounded away from zero and so reads 128.
   function automatic logic [ColorWidth-1:0] sine_value(input logic [SineIdxWidth-1:0] phase);
      if (!phase[7]) begin
         return half_wave(phase[6:0]);
      end
      if (phase == 8'd128) begin
         return 8'd128;
      end
      return 8'd255 - half_wave(phase[6:0]);
   endfunction

endpackage

`default_nettype wire

// File: src/ipcm_req_if.sv
// Input channel carrying one iteration count per transfer.
// Depends on ipcm_pkg for the field width.
`default_nettype none

interface ipcm_req_if;
   logic                             valid;
   logic                             ready;
   logic [ipcm_pkg::CountWidth-1:0]  iteration_count;

   modport source (output valid, output iteration_count, input ready);
   modport sink   (input valid, input iteration_count, output ready);
endinterface

`default_nettype wire

// File: src/ipcm_rsp_if.sv
// Result channel carrying one RGB pixel per transfer.
// Depends on ipcm_pkg for the field widths.
`default_nettype none

interface ipcm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ipcm_pkg::ColorWidth-1:0]  red;
   logic [ipcm_pkg::ColorWidth-1:0]  green;
   logic [ipcm_pkg::ColorWidth-1:0]  blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// File: src/ipcm_divider.sv
// Pipelined restoring divider producing the fraction count * 2^FRAC_BITS / limit,
// one quotient bit per stage, plus the inside-the-set flag. Depends on ipcm_pkg.
`default_nettype none

module ipcm_divider #(
   parameter int FRAC_BITS = ipcm_pkg::FracBitsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [ipcm_pkg::CountWidth-1:0]     max_iterations,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [ipcm_pkg::CountWidth-1:0]     in_count,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic                                     out_black,
   output logic [FRAC_BITS-1:0]                     out_frac
);

   localparam int CW = ipcm_pkg::CountWidth;

   logic [FRAC_BITS:0]   valid_ff;
   logic [FRAC_BITS:0]   valid_in;
   logic [FRAC_BITS+1:0] load;
   logic [CW-1:0]        rem_ff   [0:FRAC_BITS];
   logic [CW-1:0]        rem_in   [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] quo_ff   [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] quo_in   [0:FRAC_BITS];
   logic [FRAC_BITS:0]   black_ff;
   logic [FRAC_BITS:0]   black_in;

   assign load[FRAC_BITS+1] = out_ready;
   assign valid_in[0]       = in_valid;
   assign rem_in[0]         = in_count;
   assign quo_in[0]         = '0;
   assign black_in[0]       = (in_count >= max_iterations);

   for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_step
      logic [CW:0] dbl;
      logic [CW:0] diff;
      logic        qbit;

      assign dbl         = {rem_ff[i-1], 1'b0};
      assign diff        = dbl - {1'b0, max_iterations};
      assign qbit        = !diff[CW];
      assign rem_in[i]   = qbit ? diff[CW-1:0] : dbl[CW-1:0];
      assign quo_in[i]   = {quo_ff[i-1][FRAC_BITS-2:0], qbit};
      assign black_in[i] = black_ff[i-1];
      assign valid_in[i] = valid_ff[i-1];
   end

   for (genvar i = 0; i <= FRAC_BITS; i++) begin : g_stage
      assign load[i] = !valid_ff[i] || load[i+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (load[i]) begin
            valid_ff[i] <= valid_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (load[i]) begin
            rem_ff[i]   <= rem_in[i];
            quo_ff[i]   <= quo_in[i];
            black_ff[i] <= black_in[i];
         end
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[FRAC_BITS];
   assign out_black = black_ff[FRAC_BITS];
   assign out_frac  = quo_ff[FRAC_BITS];

   a_rem_below_limit: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[FRAC_BITS] && !black_ff[FRAC_BITS]) |-> (rem_ff[FRAC_BITS] < max_iterations))
      else $error("Division remainder reached the iteration limit.");

endmodule

`default_nettype wire

// File: src/ipcm_shader.sv
// Colour stage: forms the ramp products and sine lookups from the fraction, then
// selects the palette into the output register. Depends on ipcm_pkg.
`default_nettype none

module ipcm_shader #(
   parameter int FRAC_BITS = ipcm_pkg::FracBitsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [ipcm_pkg::PaletteWidth-1:0]   palette,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic                                in_black,
   input  wire logic [FRAC_BITS-1:0]                in_frac,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic [ipcm_pkg::ColorWidth-1:0]          out_red,
   output logic [ipcm_pkg::ColorWidth-1:0]          out_green,
   output logic [ipcm_pkg::ColorWidth-1:0]          out_blue
);

   localparam int PW  = FRAC_BITS + 8;
   localparam int UW  = FRAC_BITS - 2;
   localparam int SW  = ipcm_pkg::SineIdxWidth;
   localparam logic [UW:0] Quarter = {1'b1, {UW{1'b0}}};

   typedef logic [ipcm_pkg::ColorWidth-1:0] color_type;

   logic [PW-1:0]   prod_ramp;
   logic [PW-1:0]   prod_vr;
   logic [PW-1:0]   prod_vb;
   logic [UW-1:0]   frac_low;
   logic [UW:0]     down_base;
   logic [UW+7:0]   prod_up;
   logic [UW+7:0]   prod_down;
   logic [SW-1:0]   sine_idx;

   color_type ramp_in, orange_in, vr_in, vb_in, up_in, down_in, sr_in, sg_in, sb_in;
   color_type ramp_ff, orange_ff, vr_ff, vb_ff, up_ff, down_ff, sr_ff, sg_ff, sb_ff;
   logic [1:0] seg_ff;
   logic       black_ff;
   logic       s1_valid_ff;
   logic       s1_load;
   logic       out_load;

   color_type red_in, green_in, blue_in;
   color_type red_ff, green_ff, blue_ff;
   logic      out_valid_ff;

   assign prod_ramp = {8'd0, in_frac} * PW'(ipcm_pkg::RampGain);
   assign prod_vr   = {8'd0, in_frac} * PW'(ipcm_pkg::VioletRGain);
   assign prod_vb   = {8'd0, in_frac} * PW'(ipcm_pkg::VioletBGain);
   assign frac_low  = in_frac[UW-1:0];
   assign down_base = Quarter - {1'b0, frac_low};
   assign prod_up   = {8'd0, frac_low} * (UW+8)'(ipcm_pkg::RampGain);
   assign prod_down = {7'd0, down_base} * (UW+8)'(ipcm_pkg::RampGain);
   assign sine_idx  = in_frac[FRAC_BITS-1 -: SW];

   assign ramp_in   = prod_ramp[FRAC_BITS+7:FRAC_BITS];
   assign orange_in = {1'b0, prod_ramp[FRAC_BITS+7:FRAC_BITS+1]};
   assign vr_in     = prod_vr[FRAC_BITS+7:FRAC_BITS];
   assign vb_in     = prod_vb[FRAC_BITS+7:FRAC_BITS];
   assign up_in     = prod_up[UW+7:UW];
   assign down_in   = prod_down[UW+7:UW];
   assign sr_in     = ipcm_pkg::sine_value(sine_idx);
   assign sg_in     = ipcm_pkg::sine_value(sine_idx + SW'(ipcm_pkg::SineOffsetG));
   assign sb_in     = ipcm_pkg::sine_value(sine_idx + SW'(ipcm_pkg::SineOffsetB));

   assign out_load = !out_valid_ff || out_ready;
   assign s1_load  = !s1_valid_ff || out_load;
   assign in_ready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         ramp_ff   <= ramp_in;
         orange_ff <= orange_in;
         vr_ff     <= vr_in;
         vb_ff     <= vb_in;
         up_ff     <= up_in;
         down_ff   <= down_in;
         sr_ff     <= sr_in;
         sg_ff     <= sg_in;
         sb_ff     <= sb_in;
         seg_ff    <= in_frac[FRAC_BITS-1:FRAC_BITS-2];
         black_ff  <= in_black;
      end
   end

   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      case (ipcm_pkg::palette_type'(palette))
         ipcm_pkg::PAL_GRAY: begin
            red_in   = ramp_ff;
            green_in = ramp_ff;
            blue_in  = ramp_ff;
         end
         ipcm_pkg::PAL_RED: begin
            red_in = ramp_ff;
         end
         ipcm_pkg::PAL_ORANGE: begin
            red_in   = ramp_ff;
            green_in = orange_ff;
         end
         ipcm_pkg::PAL_YELLOW: begin
            red_in   = ramp_ff;
            green_in = ramp_ff;
         end
         ipcm_pkg::PAL_GREEN: begin
            green_in = ramp_ff;
         end
         ipcm_pkg::PAL_CYAN: begin
            green_in = ramp_ff;
            blue_in  = ramp_ff;
         end
         ipcm_pkg::PAL_BLUE: begin
            blue_in = ramp_ff;
         end
         ipcm_pkg::PAL_VIOLET: begin
            red_in  = vr_ff;
            blue_in = vb_ff;
         end
         ipcm_pkg::PAL_SINE: begin
            red_in   = sr_ff;
            green_in = sg_ff;
            blue_in  = sb_ff;
         end
         ipcm_pkg::PAL_PIECEWISE: begin
            case (seg_ff)
               2'd0: begin
                  blue_in = up_ff;
               end
               2'd1: begin
                  green_in = up_ff;
                  blue_in  = 8'd255;
               end
               2'd2: begin
                  red_in   = up_ff;
                  green_in = 8'd255;
                  blue_in  = 8'd255;
               end
               default: begin
                  red_in   = 8'd255;
                  green_in = 8'd255;
                  blue_in  = down_ff;
               end
            endcase
         end
         default: begin
         end
      endcase
      if (black_ff) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

   a_black_inside: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_load && black_ff)
      |=> (red_ff == '0 && green_ff == '0 && blue_ff == '0))
      else $error("A pixel inside the set did not come out black.");

   a_top_segment_red: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_load && !black_ff && seg_ff == 2'd3
       && palette == ipcm_pkg::PAL_PIECEWISE)
      |=> (red_ff == 8'd255 && green_ff == 8'd255))
      else $error("Top piecewise segment did not saturate red and green.");

endmodule

`default_nettype wire

// File: src/iteration_palette_colormap.sv
// Escape-time palette colormap: each input transfer passes through the divider pipeline,
// one quotient bit per stage, and then the shader's product and output registers.
// Throughput is one pixel per cycle; stalls on the result side fill the pipeline.
// Synchronous reset empties the pipeline and sets the limit to 256 and the palette to gray.
// Depends on ipcm_pkg, ipcm_req_if, ipcm_rsp_if, ipcm_divider and ipcm_shader.
`default_nettype none

module iteration_palette_colormap #(
   parameter int FRAC_BITS = ipcm_pkg::FracBitsDefault
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   ipcm_req_if.sink                                   req_chan,
   ipcm_rsp_if.source                                 rsp_chan,
   input  wire logic                                  csr_wr_en,
   input  wire logic [ipcm_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [ipcm_pkg::CsrDataWidth-1:0]     csr_wr_data
);

   logic [ipcm_pkg::CountWidth-1:0]   max_iter_ff;
   logic [ipcm_pkg::CountWidth-1:0]   max_iter_in;
   logic [ipcm_pkg::PaletteWidth-1:0] palette_ff;
   logic [ipcm_pkg::PaletteWidth-1:0] palette_in;

   logic                 div_valid;
   logic                 div_ready;
   logic                 div_black;
   logic [FRAC_BITS-1:0] div_frac;

   always_comb begin
      max_iter_in = max_iter_ff;
      palette_in  = palette_ff;
      if (csr_wr_en) begin
         case (ipcm_pkg::csr_index_type'(csr_index))
            ipcm_pkg::CSR_MAX_ITERATIONS: begin
               max_iter_in = csr_wr_data[ipcm_pkg::CountWidth-1:0];
            end
            ipcm_pkg::CSR_PALETTE: begin
               palette_in = csr_wr_data[ipcm_pkg::PaletteWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= ipcm_pkg::MaxIterReset;
         palette_ff  <= ipcm_pkg::PaletteReset;
      end else begin
         max_iter_ff <= max_iter_in;
         palette_ff  <= palette_in;
      end
   end

   ipcm_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock          (clock),
      .reset          (reset),
      .max_iterations (max_iter_ff),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .in_count       (req_chan.iteration_count),
      .out_valid      (div_valid),
      .out_ready      (div_ready),
      .out_black      (div_black),
      .out_frac       (div_frac)
   );

   ipcm_shader #(
      .FRAC_BITS (FRAC_BITS)
   ) u_shader (
      .clock     (clock),
      .reset     (reset),
      .palette   (palette_ff),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_black  (div_black),
      .in_frac   (div_frac),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_red   (rsp_chan.red),
      .out_green (rsp_chan.green),
      .out_blue  (rsp_chan.blue)
   );

   a_limit_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && csr_index == ipcm_pkg::CSR_MAX_ITERATIONS)
      |=> (max_iter_ff == $past(csr_wr_data)))
      else $error("Iteration limit write was not taken.");

endmodule

`default_nettype wire

// File: dv/iteration_palette_colormap_tb.sv
// Self-checking testbench for iteration_palette_colormap: drives iteration counts,
// predicts each RGB pixel from the limit and palette registers and checks every transfer.
// Depends on ipcm_pkg, ipcm_req_if, ipcm_rsp_if and the block itself.
`timescale 1ns / 100ps

module iteration_palette_colormap_tb;

   localparam int FracBits   = ipcm_pkg::FracBitsDefault;
   localparam int CycleLimit = 400000;

   localparam logic [7:0] SineQuarter [0:64] = '{
      8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
      8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185,
      8'd188, 8'd190, 8'd193, 8'd196, 8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211,
      8'd213, 8'd215, 8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
      8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244, 8'd245, 8'd246,
      8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254,
      8'd254, 8'd255, 8'd255, 8'd255, 8'd255
   };

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_wr_en;
   logic [ipcm_pkg::CsrIndexWidth-1:0] csr_index;
   logic [ipcm_pkg::CsrDataWidth-1:0]  csr_wr_data;

   ipcm_req_if req_bus ();
   ipcm_rsp_if rsp_bus ();

   iteration_palette_colormap u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   logic [15:0] limit_reg;
   logic [3:0]  palette_reg;
   logic [15:0] pending_counts [$];
   pixel_type   expected_pixels [$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          mismatch_count;
   int          cycle_count;

   function automatic logic [7:0] ramp(input logic [63:0] frac, input logic [63:0] gain);
      logic [63:0] prod;
      prod = (frac * gain) >> FracBits;
      return prod[7:0];
   endfunction

   function automatic logic [7:0] sine_lookup(input logic [7:0] phase);
      logic [6:0] low;
      logic [7:0] h;
      low = phase[6:0];
      h = (low <= 7'd64) ? SineQuarter[low] : SineQuarter[8'd128 - {1'b0, low}];
      if (!phase[7]) begin
         return h;
      end
      if (phase == 8'd128) begin
         return 8'd128;
      end
      return 8'd255 - h;
   endfunction

   function automatic pixel_type shade_pixel(input logic [15:0] count, input logic [15:0] limit,
                                             input logic [3:0] pal);
      pixel_type   px;
      logic [63:0] frac;
      logic [63:0] quarter;
      logic [63:0] prod;
      logic [7:0]  phase;
      px = '0;
      quarter = 64'd1 << (FracBits - 2);
      if (count < limit) begin
         frac = ({48'd0, count} << FracBits) / {48'd0, limit};
         case (ipcm_pkg::palette_type'(pal))
            ipcm_pkg::PAL_GRAY: begin
               px.red = ramp(frac, ipcm_pkg::RampGain);
               px.green = px.red;
               px.blue = px.red;
            end
            ipcm_pkg::PAL_RED: px.red = ramp(frac, ipcm_pkg::RampGain);
            ipcm_pkg::PAL_ORANGE: begin
               px.red = ramp(frac, ipcm_pkg::RampGain);
               prod = (frac * ipcm_pkg::RampGain) >> (FracBits + 1);
               px.green = prod[7:0];
            end
            ipcm_pkg::PAL_YELLOW: begin
               px.red = ramp(frac, ipcm_pkg::RampGain);
               px.green = px.red;
            end
            ipcm_pkg::PAL_GREEN: px.green = ramp(frac, ipcm_pkg::RampGain);
            ipcm_pkg::PAL_CYAN: begin
               px.green = ramp(frac, ipcm_pkg::RampGain);
               px.blue = px.green;
            end
            ipcm_pkg::PAL_BLUE: px.blue = ramp(frac, ipcm_pkg::RampGain);
            ipcm_pkg::PAL_VIOLET: begin
               px.red = ramp(frac, ipcm_pkg::VioletRGain);
               px.blue = ramp(frac, ipcm_pkg::VioletBGain);
            end
            ipcm_pkg::PAL_SINE: begin
               prod = (frac * ipcm_pkg::SineDepth) >> FracBits;
               phase = prod[7:0];
               px.red = sine_lookup(phase);
               px.green = sine_lookup(phase + 8'(ipcm_pkg::SineOffsetG));
               px.blue = sine_lookup(phase + 8'(ipcm_pkg::SineOffsetB));
            end
            ipcm_pkg::PAL_PIECEWISE: begin
               if (frac < quarter) begin
                  px.blue = ramp(frac, 1020);
               end else if (frac < 2 * quarter) begin
                  px.green = ramp(frac - quarter, 1020);
                  px.blue = 8'd255;
               end else if (frac < 3 * quarter) begin
                  px.red = ramp(frac - 2 * quarter, 1020);
                  px.green = 8'd255;
                  px.blue = 8'd255;
               end else begin
                  px.red = 8'd255;
                  px.green = 8'd255;
                  px.blue = ramp((64'd1 << FracBits) - 4 * (frac - 3 * quarter),
                                 ipcm_pkg::RampGain);
               end
            end
            default: px = '0;
         endcase
      end
      return px;
   endfunction

   initial begin
      clock = 1'b0;
   end

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("iteration_palette_colormap regression: fail");
         $finish;
      end
   end

   // Driver: holds a pending transfer until it is taken, otherwise may idle.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_pixels.push_back(shade_pixel(req_bus.iteration_count, limit_reg,
                                                  palette_reg));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_counts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.iteration_count <= pending_counts.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls the result channel at random and checks each transfer.
   always @(posedge clock) begin
      pixel_type seen;
      pixel_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.red, rsp_bus.green, rsp_bus.blue};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel, expected none, got %h %h %h", $time,
                        seen.red, seen.green, seen.blue);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (seen.red !== want.red || seen.green !== want.green
                   || seen.blue !== want.blue) begin
                  $display("%0t: pixel mismatch, expected %h %h %h, got %h %h %h", $time,
                           want.red, want.green, want.blue, seen.red, seen.green, seen.blue);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

   task automatic csr_write(input ipcm_pkg::csr_index_type idx, input logic [15:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      if (idx == ipcm_pkg::CSR_MAX_ITERATIONS) begin
         limit_reg = data;
      end else begin
         palette_reg = data[3:0];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every transfer has been checked, then lets the pipeline settle.
   task automatic drain();
      while (pending_counts.size() != 0 || req_bus.valid || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (25) @(posedge clock);
   endtask

   task automatic directed_phase(input logic [15:0] limit, input logic [15:0] pal_word,
                                 input logic [15:0] counts [$]);
      drain();
      csr_write(ipcm_pkg::CSR_MAX_ITERATIONS, limit);
      csr_write(ipcm_pkg::CSR_PALETTE, pal_word);
      foreach (counts[i]) begin
         pending_counts.push_back(counts[i]);
      end
   endtask

   initial begin
      int          lim;
      int          pick;
      int          near;
      logic [3:0]  pal;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = ipcm_pkg::CSR_MAX_ITERATIONS;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.iteration_count = '0;
      rsp_bus.ready = 1'b0;
      limit_reg = ipcm_pkg::MaxIterReset;
      palette_reg = ipcm_pkg::PaletteReset;
      mismatch_count = 0;
      cycle_count = 0;
      send_idle_pct = 12;
      recv_idle_pct = 82;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset values first, then the palette boundaries and the special cases.
      pending_counts.push_back(16'd0);
      pending_counts.push_back(16'd255);
      pending_counts.push_back(16'd256);
      pending_counts.push_back(16'hFFFF);
      directed_phase(16'hFFFF, {12'hFFF, 4'(ipcm_pkg::PAL_PIECEWISE)},
                     '{16'd0, 16'd16383, 16'd16384, 16'd32767, 16'd32768, 16'd49151,
                       16'd49152, 16'hFFFE});
      directed_phase(16'd1, {12'hA5A, 4'(ipcm_pkg::PAL_SINE)}, '{16'd0, 16'd1, 16'hFFFF});
      directed_phase(16'd0, {12'h000, 4'(ipcm_pkg::PAL_GRAY)}, '{16'd0, 16'hFFFF});
      directed_phase(16'd1000, 16'h000C, '{16'd0, 16'd500});
      directed_phase(16'hFFFF, {12'h5A5, 4'(ipcm_pkg::PAL_VIOLET)}, '{16'hFFFE, 16'd0});

      for (int ph = 0; ph < 38; ph++) begin
         drain();
         if (ph == 12) begin
            send_idle_pct = 82;
            recv_idle_pct = 12;
         end else if (ph == 24) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(9))
            0: lim = 1;
            1: lim = 65535;
            2: lim = $urandom_range(2, 16);
            3, 4, 5: lim = $urandom_range(1, 1023);
            default: lim = $urandom_range(1, 65535);
         endcase
         pal = (ph < 20) ? 4'(ph % 10) : 4'($urandom_range(15));
         csr_write(ipcm_pkg::CSR_MAX_ITERATIONS, 16'(lim));
         csr_write(ipcm_pkg::CSR_PALETTE, {12'($urandom_range(4095)), pal});
         for (int n = 0; n < 50; n++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               pending_counts.push_back(16'($urandom_range(lim - 1)));
            end else if (pick < 70) begin
               near = lim - 1 + $urandom_range(2);
               pending_counts.push_back(16'((near > 65535) ? 65535 : near));
            end else begin
               pending_counts.push_back(16'($urandom_range(65535)));
            end
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("iteration_palette_colormap regression: pass");
      end else begin
         $display("iteration_palette_colormap regression: fail");
      end
      $finish;
   end

endmodule
